FILE: rtl/core/mbpq_pkg.sv
// ============================================================================
// mbpq_pkg
// Shared constants, operation and status codes, and controller/datapath
// command and status types for the mailbox block pool queue.
// ============================================================================
package mbpq_pkg;

    // Pool geometry
    localparam int NUM_BLOCKS = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);       // block index
    localparam int LINK_W     = $clog2(NUM_BLOCKS + 1);   // index or null link
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);   // mailbox fill count

    // Field widths
    localparam int FUNC_W     = 3;
    localparam int BLK_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int OUT_IDX_W  = 4;
    localparam int ADDR_W     = 32;
    localparam int BSIZE_W    = 13;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_POOL_BASE   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_BYTES = 1'd1;
    localparam logic [BSIZE_W-1:0]    BLOCK_BYTES_RST = 13'd32;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ZALLOC = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FREE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_PUT    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_GET    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_BLOCK = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MBX_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MBX_EMPTY = 3'd4;

    // Stream packing
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // latch item and issue table/ring reads
        logic commit;   // apply operation and load the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_full; // output register holds an item not yet taken
    } t_dp_stat;

endpackage

FILE: rtl/core/mbpq_ctrl.sv
// ============================================================================
// mbpq_ctrl
// Two-state sequencer: accept an item, then commit it once the output
// register can take its result.
// ============================================================================
module mbpq_ctrl import mbpq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  logic     i_m_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    // Ready only between items; reads go out on acceptance
    assign o_s_tready   = (r_state == S_IDLE);
    assign o_cmd.load   = o_s_tready && i_s_tvalid;
    assign o_cmd.commit = (r_state == S_EXEC) && (!i_stat.out_full || i_m_tready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted item always moves to execution
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execution");

    // Commit never overwrites a result still waiting downstream
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!i_stat.out_full || i_m_tready))
        else $error("commit while output register blocked");

    // No new item is taken while one is executing
    a_no_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !o_cmd.load)
        else $error("item accepted during execution");

endmodule

FILE: rtl/core/mbpq_dp.sv
// ============================================================================
// mbpq_dp
// Datapath: configuration registers, free-list link table, mailbox ring,
// pointers, address computation and the output register.
// ============================================================================
module mbpq_dp import mbpq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [BLK_W-1:0]      i_blk,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [OUT_IDX_W-1:0]  o_out_index,
    output logic [ADDR_W-1:0]     o_out_address,
    output logic                  o_zero_fill
);

    // Configuration
    logic [ADDR_W-1:0]  r_pool_base;
    logic [BSIZE_W-1:0] r_block_bytes;

    // Latched item
    logic [FUNC_W-1:0]  r_func;
    logic [BLK_W-1:0]   r_blk;

    // Pool and mailbox state
    logic [LINK_W-1:0]     r_free_head;
    logic [IDX_W-1:0]      r_put_pos;
    logic [IDX_W-1:0]      r_get_pos;
    logic [CNT_W-1:0]      r_mail_count;
    logic [NUM_BLOCKS-1:0] r_link_vld;

    // Memories with registered reads
    logic [LINK_W-1:0] link_mem [NUM_BLOCKS];
    logic [IDX_W-1:0]  ring_mem [NUM_BLOCKS];
    logic [LINK_W-1:0] r_link_q;
    logic              r_link_q_vld;
    logic [IDX_W-1:0]  r_ring_q;

    // Output register
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [OUT_IDX_W-1:0] r_out_index;
    logic [ADDR_W-1:0]    r_out_address;
    logic                 r_zero_fill;

    // Operation results
    logic [STATUS_W-1:0]  res_status;
    logic [IDX_W-1:0]     res_idx;
    logic                 res_valid;
    logic                 res_fill;
    logic                 link_we;
    logic                 ring_we;
    logic [LINK_W-1:0]    n_free_head;
    logic [IDX_W-1:0]     n_put_pos;
    logic [IDX_W-1:0]     n_get_pos;
    logic [CNT_W-1:0]     n_mail_count;
    logic [LINK_W-1:0]    head_link;
    logic                 blk_ok;
    logic                 head_null;
    logic                 mbx_full;
    logic                 mbx_empty;
    logic [IDX_W+BSIZE_W-1:0] offset;
    logic [ADDR_W-1:0]    res_addr;

    // Never-written link entries read as their reset chain value
    assign head_link = r_link_q_vld ? r_link_q : (r_free_head + LINK_W'(1));
    assign blk_ok    = ({1'b0, r_blk} < (BLK_W+1)'(NUM_BLOCKS));
    assign head_null = (r_free_head >= LINK_W'(NUM_BLOCKS));
    assign mbx_full  = (r_mail_count >= CNT_W'(NUM_BLOCKS));
    assign mbx_empty = (r_mail_count == '0);

    // Decode operation
    always_comb begin
        res_status   = ST_OK;
        res_idx      = '0;
        res_valid    = 1'b0;
        res_fill     = 1'b0;
        link_we      = 1'b0;
        ring_we      = 1'b0;
        n_free_head  = r_free_head;
        n_put_pos    = r_put_pos;
        n_get_pos    = r_get_pos;
        n_mail_count = r_mail_count;
        unique case (r_func)
            FN_ALLOC, FN_ZALLOC: begin
                if (head_null) begin
                    res_status = ST_NO_BLOCK;
                end else begin
                    res_idx     = r_free_head[IDX_W-1:0];
                    res_valid   = 1'b1;
                    res_fill    = (r_func == FN_ZALLOC);
                    n_free_head = head_link;
                end
            end
            FN_FREE: begin
                if (!blk_ok) begin
                    res_status = ST_BAD_BLOCK;
                end else begin
                    link_we     = 1'b1;
                    n_free_head = LINK_W'(r_blk);
                end
            end
            FN_PUT: begin
                if (!blk_ok) begin
                    res_status = ST_BAD_BLOCK;
                end else if (mbx_full) begin
                    res_status = ST_MBX_FULL;
                end else begin
                    ring_we      = 1'b1;
                    n_put_pos    = (r_put_pos == IDX_W'(NUM_BLOCKS - 1)) ? '0
                                 : r_put_pos + IDX_W'(1);
                    n_mail_count = r_mail_count + CNT_W'(1);
                end
            end
            FN_GET: begin
                if (mbx_empty) begin
                    res_status = ST_MBX_EMPTY;
                end else begin
                    res_idx      = r_ring_q;
                    res_valid    = 1'b1;
                    n_get_pos    = (r_get_pos == IDX_W'(NUM_BLOCKS - 1)) ? '0
                                 : r_get_pos + IDX_W'(1);
                    n_mail_count = r_mail_count - CNT_W'(1);
                end
            end
            default: res_status = ST_BAD_BLOCK;
        endcase
    end

    // Block address: base plus index times size, wrapping at 32 bits
    assign offset   = res_idx * r_block_bytes;
    assign res_addr = r_pool_base + ADDR_W'(offset);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_block_bytes <= BLOCK_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_POOL_BASE:   r_pool_base   <= i_cfg_wdata;
                CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_wdata[BSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Latch item and read link table and ring on acceptance
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func       <= i_func;
            r_blk        <= i_blk;
            r_link_q     <= link_mem[r_free_head[IDX_W-1:0]];
            r_link_q_vld <= r_link_vld[r_free_head[IDX_W-1:0]];
            r_ring_q     <= ring_mem[r_get_pos];
        end
    end

    // Memory writes on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && link_we) begin
            link_mem[r_blk[IDX_W-1:0]] <= r_free_head;
        end
        if (i_cmd.commit && ring_we) begin
            ring_mem[r_put_pos] <= r_blk[IDX_W-1:0];
        end
    end

    // Pool and mailbox state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= '0;
            r_put_pos    <= '0;
            r_get_pos    <= '0;
            r_mail_count <= '0;
            r_link_vld   <= '0;
        end else if (i_cmd.commit) begin
            r_free_head  <= n_free_head;
            r_put_pos    <= n_put_pos;
            r_get_pos    <= n_get_pos;
            r_mail_count <= n_mail_count;
            if (link_we) begin
                r_link_vld[r_blk[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // Output valid: set on commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status      <= res_status;
            r_out_index   <= res_valid ? OUT_IDX_W'(res_idx) : '0;
            r_out_address <= res_valid ? res_addr : '0;
            r_zero_fill   <= res_fill;
        end
    end

    assign o_stat.out_full = r_out_valid;
    assign o_m_tvalid      = r_out_valid;
    assign o_status        = r_status;
    assign o_out_index     = r_out_index;
    assign o_out_address   = r_out_address;
    assign o_zero_fill     = r_zero_fill;

    // Mailbox count never exceeds the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mail_count <= CNT_W'(NUM_BLOCKS))
        else $error("mailbox count overflow");

    // Ring pointers stay consistent with the fill count
    a_ring_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        IDX_W'(r_get_pos + r_mail_count[IDX_W-1:0]) == r_put_pos)
        else $error("ring pointers disagree with count");

    // Free head is a block or the null link
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= LINK_W'(NUM_BLOCKS))
        else $error("free head out of range");

    // Zero-fill only on a successful allocation
    a_fill_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_zero_fill) |-> (r_status == ST_OK))
        else $error("zero fill flagged on failed operation");

endmodule

FILE: rtl/core/mail_block_pool_queue_top.sv
// ============================================================================
// mail_block_pool_queue_top
// Fixed-size block pool on a linked free list with a mailbox ring of indices.
// ============================================================================
// Each item is accepted, then committed. Acceptance issues registered reads
// of the link table (at the free-list head) and of the mailbox ring (at the
// get position); the commit, which waits while a result is held downstream,
// applies the operation and loads the output register. No new item is
// accepted before the last one commits; a result that waits downstream holds
// back only the commit of the following item, not its acceptance. The link
// table resets to the chain 0..N-1 through per-entry valid bits, so no
// clearing pass is needed. Configuration is taken in any cycle on the write port.
module mail_block_pool_queue_top import mbpq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Input items
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [7:0] block_index
    input  logic [S_TUSER_W-1:0]  i_s_tuser,   // [2:0] func
    // Result items
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // [3:0] out_index, [35:4] out_address
    output logic [M_TUSER_W-1:0]  o_m_tuser    // [2:0] status, [3] zero_fill
);

    t_dp_cmd              cmd;
    t_dp_stat             stat;
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] out_index;
    logic [ADDR_W-1:0]    out_address;
    logic                 zero_fill;

    // Sequencer
    mbpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath
    mbpq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_func        (i_s_tuser),
        .i_blk         (i_s_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_status      (status),
        .o_out_index   (out_index),
        .o_out_address (out_address),
        .o_zero_fill   (zero_fill)
    );

    // Pack result fields
    assign o_m_tdata = {4'b0000, out_address, out_index};
    assign o_m_tuser = {zero_fill, status};

endmodule
